// ----- rtl/tpa_pkg.sv -----
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared types and constants for the triac phase-angle firing controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tpa_pkg;

  typedef enum logic [1:0] {
    CmdTick    = 2'd0,
    CmdCross   = 2'd1,
    CmdDuty    = 2'd2,
    CmdThermal = 2'd3
  } cmd_e;

  localparam int CppW   = 16;
  localparam int PulseW = 16;
  localparam int DutyW  = 7;
  localparam int ReqW   = 8;
  localparam int CrossW = 32;
  // cycles_per_percent times (100 - duty)
  localparam int ProdW  = CppW + DutyW;

  localparam logic [DutyW-1:0]  DutyFull   = 7'd100;
  localparam logic [ReqW-1:0]   DutyFloor  = 8'd2;
  localparam logic [CppW-1:0]   CppReset   = 16'd4800;
  localparam logic [PulseW-1:0] PulseReset = 16'd2400;

  // register map: one 32-bit word each, index taken from paddr[2]
  localparam int   AddrW    = 3;
  localparam logic RegCpp   = 1'b0;
  localparam logic RegPulse = 1'b1;

  typedef struct packed {
    logic [CppW-1:0]   cycles_per_percent;
    logic [PulseW-1:0] pulse_cycles;
  } cfg_t;

  typedef struct packed {
    logic [1:0]      cmd;
    logic [ReqW-1:0] duty_request;
  } item_t;

  typedef struct packed {
    logic              gate_out;
    logic [DutyW-1:0]  duty_now;
    logic [CrossW-1:0] crossings_seen;
    logic              overheat_seen;
  } result_t;

  function automatic logic [DutyW-1:0] clamp_duty(input logic [ReqW-1:0] req);
    logic [DutyW-1:0] res;
    if (req > ReqW'(DutyFull)) begin
      res = DutyFull;
    end else if (req <= DutyFloor) begin
      res = '0;
    end else begin
      res = req[DutyW-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/tpa_if.sv -----
// ----------------------------------------------------------------------------
// tpa_in_if / tpa_out_if
// Valid/ready channels for command items and controller results.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpa_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] duty_request;

  modport source (output valid, output cmd, output duty_request, input ready);
  modport sink (input valid, input cmd, input duty_request, output ready);
endinterface

interface tpa_out_if;
  logic        valid;
  logic        ready;
  logic        gate_out;
  logic [6:0]  duty_now;
  logic [31:0] crossings_seen;
  logic        overheat_seen;

  modport source (output valid, output gate_out, output duty_now,
                  output crossings_seen, output overheat_seen, input ready);
  modport sink (input valid, input gate_out, input duty_now,
                input crossings_seen, input overheat_seen, output ready);
endinterface

`default_nettype wire

// ----- rtl/triac_phase_angle_firing.sv -----
// A taken command is held in the input register, then its result in the result register.
// Throughput: 1 item per cycle unless the result side stalls; the state update follows the
// input register, with the timer compare and the 16x7 delay multiply in that path.
// The input and result registers each hold one item, so either side may stall.
// Reset (rst_ni low, asynchronous): gate, timer, duty, counters and flag clear,
// phase step returns to 4800 and pulse width to 2400.
// ----------------------------------------------------------------------------
// triac_phase_angle_firing
// Phase-angle triac gate controller with APB configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module triac_phase_angle_firing
  import tpa_pkg::*;
#(
  parameter int TIMER_WIDTH = 24
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  tpa_in_if.sink                in_if,
  tpa_out_if.source             out_if,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  cfg_t    cfg;
  item_t   item_q;
  logic    in_valid_q;
  result_t res;
  result_t res_q;
  logic    out_valid_q;
  logic    advance;

  tpa_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // item moves into the state update when the result register frees up
  assign advance     = in_valid_q && (!out_valid_q || out_if.ready);
  assign in_if.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      item_q.cmd          <= in_if.cmd;
      item_q.duty_request <= in_if.duty_request;
    end
  end

  tpa_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.gate_out       = res_q.gate_out;
  assign out_if.duty_now       = res_q.duty_now;
  assign out_if.crossings_seen = res_q.crossings_seen;
  assign out_if.overheat_seen  = res_q.overheat_seen;

endmodule

`default_nettype wire

// ----- rtl/tpa_cfg.sv -----
// ----------------------------------------------------------------------------
// tpa_cfg
// APB register file holding the phase step and the gate pulse width.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_cfg
  import tpa_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [CppW-1:0]   cpp_q;
  logic [PulseW-1:0] pulse_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpp_q   <= CppReset;
      pulse_q <= PulseReset;
    end else if (wr_en) begin
      case (paddr[2])
        RegCpp:   cpp_q   <= pwdata[CppW-1:0];
        RegPulse: pulse_q <= pwdata[PulseW-1:0];
        default:  ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      RegCpp:   prdata = 32'(cpp_q);
      RegPulse: prdata = 32'(pulse_q);
      default:  prdata = '0;
    endcase
  end

  assign cfg_o.cycles_per_percent = cpp_q;
  assign cfg_o.pulse_cycles       = pulse_q;

endmodule

`default_nettype wire

// ----- rtl/tpa_core.sv -----
// ----------------------------------------------------------------------------
// tpa_core
// Controller state: duty, one-shot timer, armed mark, gate and counters.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_core
  import tpa_pkg::*;
#(
  parameter int TIMER_WIDTH = 24
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire item_t item_i,
  input  wire cfg_t  cfg_i,
  output result_t    res_o
);

  localparam int ExtW = (TIMER_WIDTH > ProdW) ? TIMER_WIDTH : ProdW;

  logic                   gate_q, gate_d;
  logic                   armed_q, armed_d;
  logic                   run_q, run_d;
  logic [TIMER_WIDTH-1:0] count_q, count_d;
  logic [TIMER_WIDTH-1:0] target_q, target_d;
  logic [DutyW-1:0]       duty_q, duty_d;
  logic [CrossW-1:0]      cross_q, cross_d;
  logic                   hot_q, hot_d;

  logic [TIMER_WIDTH-1:0] count_inc;
  logic [ProdW-1:0]       prod;
  logic [ExtW-1:0]        prod_ext;
  logic [TIMER_WIDTH-1:0] delay;
  logic [TIMER_WIDTH-1:0] pulse;

  assign count_inc = count_q + 1'b1;
  assign prod      = ProdW'(cfg_i.cycles_per_percent) * ProdW'(DutyFull - duty_q);
  assign prod_ext  = ExtW'(prod);
  // long delays saturate to the timer's full scale
  assign delay     = (prod_ext > ExtW'({TIMER_WIDTH{1'b1}})) ? {TIMER_WIDTH{1'b1}}
                                                             : prod_ext[TIMER_WIDTH-1:0];
  assign pulse     = TIMER_WIDTH'(cfg_i.pulse_cycles);

  always_comb begin
    gate_d   = gate_q;
    armed_d  = armed_q;
    run_d    = run_q;
    count_d  = count_q;
    target_d = target_q;
    duty_d   = duty_q;
    cross_d  = cross_q;
    hot_d    = hot_q;
    case (cmd_e'(item_i.cmd))
      CmdTick: begin
        if (run_q) begin
          count_d = count_inc;
          if (count_inc >= target_q) begin
            run_d = 1'b0;
            if (armed_q) begin
              // firing point reached: raise gate and time the pulse
              gate_d   = 1'b1;
              armed_d  = 1'b0;
              target_d = pulse;
              count_d  = '0;
              run_d    = 1'b1;
            end else begin
              gate_d = 1'b0;
            end
          end
        end
      end
      CmdCross: begin
        cross_d = cross_q + 1'b1;
        if (duty_q == DutyFull) begin
          gate_d = 1'b1;
        end else begin
          gate_d = 1'b0;
          if (duty_q != '0) begin
            target_d = delay;
            count_d  = '0;
            run_d    = 1'b1;
            armed_d  = 1'b1;
          end
        end
      end
      CmdDuty: begin
        duty_d = clamp_duty(item_i.duty_request);
      end
      CmdThermal: begin
        gate_d = 1'b0;
        duty_d = '0;
        hot_d  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q   <= 1'b0;
      armed_q  <= 1'b0;
      run_q    <= 1'b0;
      count_q  <= '0;
      target_q <= '0;
      duty_q   <= '0;
      cross_q  <= '0;
      hot_q    <= 1'b0;
    end else if (step_i) begin
      gate_q   <= gate_d;
      armed_q  <= armed_d;
      run_q    <= run_d;
      count_q  <= count_d;
      target_q <= target_d;
      duty_q   <= duty_d;
      cross_q  <= cross_d;
      hot_q    <= hot_d;
    end
  end

  assign res_o.gate_out       = gate_d;
  assign res_o.duty_now       = duty_d;
  assign res_o.crossings_seen = cross_d;
  assign res_o.overheat_seen  = hot_d;

endmodule

`default_nettype wire

// ----- rtl/tpa_checker.sv -----
// ----------------------------------------------------------------------------
// tpa_checker
// Port-level checks on the result channel of the firing controller.
// ----------------------------------------------------------------------------
`default_nettype none

module tpa_checker
  import tpa_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic              gate_out,
  input wire logic [DutyW-1:0]  duty_now,
  input wire logic [CrossW-1:0] crossings_seen,
  input wire logic              overheat_seen
);

  // a stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(gate_out) &&
      $stable(duty_now) && $stable(crossings_seen) && $stable(overheat_seen))
    else $error("result changed while stalled");

  // the thermal flag never clears short of reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && overheat_seen |=> overheat_seen)
    else $error("overheat flag cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> duty_now <= DutyFull)
    else $error("duty above full scale");

  // requests at or below the floor clamp to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> duty_now != 7'd1 && duty_now != 7'd2)
    else $error("duty below floor not clamped");

endmodule

bind triac_phase_angle_firing tpa_checker u_tpa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .gate_out       (out_if.gate_out),
  .duty_now       (out_if.duty_now),
  .crossings_seen (out_if.crossings_seen),
  .overheat_seen  (out_if.overheat_seen)
);

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triac phase-angle firing controller. Sends a
// short table of command transactions, then random duty / zero-cross / tick
// sequences under several register settings and flow-control patterns. A
// cycle-free model of the controller predicts each result the table does not give,
// and each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module testbench;
  import tpa_pkg::*;

  localparam int TimerW     = 24;
  localparam int PhaseItems = 175;
  localparam int NumPhases  = 8;
  localparam int HoldOffLen = 300;
  localparam logic [TimerW-1:0] TimerMax = '1;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] req;
    bit         typed;
    result_t    want;
  } step_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;

  tpa_in_if  cmd_ch ();
  tpa_out_if res_ch ();

  triac_phase_angle_firing dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (cmd_ch),
    .out_if  (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // controller model state and its copy of the registers
  logic [15:0]       ctl_cpp;
  logic [15:0]       ctl_pulse;
  logic              ctl_gate;
  logic              ctl_armed;
  logic              ctl_running;
  logic [TimerW-1:0] ctl_count;
  logic [TimerW-1:0] ctl_target;
  logic [6:0]        ctl_duty;
  logic [31:0]       ctl_crossings;
  logic              ctl_overheat;

  result_t   pending_results [$];
  step_row_t directed_rows [$];

  int fail_count        = 0;
  int items_sent        = 0;
  int send_idle_pct     = 0;
  int recv_stall_pct    = 0;
  int hold_off_requests = 0;

  logic [15:0] cpp_plan   [NumPhases] = '{16'd2, 16'd0, 16'd3, 16'd1,
                                         16'd65535, 16'd5, 16'd1, 16'd0};
  logic [15:0] pulse_plan [NumPhases] = '{16'd3, 16'd0, 16'd1, 16'd65535,
                                         16'd4, 16'd2, 16'd7, 16'd1};

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic string fmt_result(result_t r);
    return $sformatf("gate=%0d duty=%0d crossings=%0d overheat=%0d",
                     r.gate_out, r.duty_now, r.crossings_seen, r.overheat_seen);
  endfunction

  function automatic void report_fail(string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endfunction

  function automatic step_row_t mk_row(cmd_e c, logic [7:0] req, bit typed = 1'b0,
                                       logic gate = 1'b0, logic [6:0] duty = '0,
                                       logic [31:0] crossings = '0,
                                       logic overheat = 1'b0);
    step_row_t row;
    row.cmd                 = c;
    row.req                 = req;
    row.typed               = typed;
    row.want.gate_out       = gate;
    row.want.duty_now       = duty;
    row.want.crossings_seen = crossings;
    row.want.overheat_seen  = overheat;
    return row;
  endfunction

  function automatic void start_delay(logic [39:0] ticks);
    ctl_target  = (ticks > 40'(TimerMax)) ? TimerMax : ticks[TimerW-1:0];
    ctl_count   = '0;
    ctl_running = 1'b1;
  endfunction

  function automatic result_t advance_controller(cmd_e c, logic [7:0] req);
    result_t r;
    case (c)
      CmdTick: begin
        if (ctl_running) begin
          ctl_count = ctl_count + 1'b1;
          if (ctl_count >= ctl_target) begin
            ctl_running = 1'b0;
            // armed expiry fires the gate and reuses the timer for the pulse
            if (ctl_armed) begin
              ctl_gate  = 1'b1;
              ctl_armed = 1'b0;
              start_delay(40'(ctl_pulse));
            end else begin
              ctl_gate = 1'b0;
            end
          end
        end
      end
      CmdCross: begin
        ctl_crossings = ctl_crossings + 1'b1;
        if (ctl_duty == DutyFull) begin
          ctl_gate = 1'b1;
        end else begin
          ctl_gate = 1'b0;
          if (ctl_duty != '0) begin
            start_delay(40'(ctl_cpp) * 40'(DutyFull - ctl_duty));
            ctl_armed = 1'b1;
          end
        end
      end
      CmdDuty: begin
        if (req > 8'(DutyFull)) begin
          ctl_duty = DutyFull;
        end else if (req <= DutyFloor) begin
          ctl_duty = '0;
        end else begin
          ctl_duty = req[6:0];
        end
      end
      default: begin
        ctl_gate     = 1'b0;
        ctl_duty     = '0;
        ctl_overheat = 1'b1;
      end
    endcase
    r.gate_out       = ctl_gate;
    r.duty_now       = ctl_duty;
    r.crossings_seen = ctl_crossings;
    r.overheat_seen  = ctl_overheat;
    return r;
  endfunction

  // entered and left at a falling edge; valid stays up for the next call
  task automatic offer_item(cmd_e c, logic [7:0] req, bit typed = 1'b0,
                            result_t want = '0);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    cmd_ch.valid        <= 1'b1;
    cmd_ch.cmd          <= c;
    cmd_ch.duty_request <= req;
    do @(posedge clk_i); while (!cmd_ch.ready);
    predicted = advance_controller(c, req);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic check_register(logic idx, logic [15:0] want);
    logic [31:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'({idx, 2'b00});
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    value = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (value !== {16'h0000, want}) begin
      report_fail($sformatf("register %0d read %0h, expected %0h", idx, value, want));
    end
  endtask

  task automatic set_register(logic idx, logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= {16'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == RegCpp) begin
      ctl_cpp = value;
    end else begin
      ctl_pulse = value;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    check_register(idx, value);
  endtask

  // result side: random stalls plus an occasional long hold-off
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_requests != holds_served) begin
        holds_served = hold_off_requests;
        hold_left    = HoldOffLen;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.gate_out       = res_ch.gate_out;
      got.duty_now       = res_ch.duty_now;
      got.crossings_seen = res_ch.crossings_seen;
      got.overheat_seen  = res_ch.overheat_seen;
      if (pending_results.size() == 0) begin
        report_fail({"unexpected result ", fmt_result(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          report_fail({"expected ", fmt_result(want), ", got ", fmt_result(got)});
        end
      end
    end
  end

  initial begin
    int         phase;
    int         phase_start;
    int         span;
    bit         drained;
    logic [7:0] duty_req;

    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.cmd          = CmdTick;
    cmd_ch.duty_request = '0;

    ctl_cpp       = CppReset;
    ctl_pulse     = PulseReset;
    ctl_gate      = 1'b0;
    ctl_armed     = 1'b0;
    ctl_running   = 1'b0;
    ctl_count     = '0;
    ctl_target    = '0;
    ctl_duty      = '0;
    ctl_crossings = '0;
    ctl_overheat  = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    check_register(RegCpp, CppReset);
    check_register(RegPulse, PulseReset);
    // short delays so the table can walk a whole firing cycle
    set_register(RegCpp, 16'd1);
    set_register(RegPulse, 16'd2);

    directed_rows.push_back(mk_row(CmdTick,    8'd0,   1'b1, 1'b0, 7'd0,   32'd0, 1'b0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd0,   1'b1, 1'b0, 7'd0,   32'd0, 1'b0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd255, 1'b1, 1'b0, 7'd100, 32'd0, 1'b0));
    directed_rows.push_back(mk_row(CmdCross,   8'd0,   1'b1, 1'b1, 7'd100, 32'd1, 1'b0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd2,   1'b1, 1'b1, 7'd0,   32'd1, 1'b0));
    directed_rows.push_back(mk_row(CmdCross,   8'hff,  1'b1, 1'b0, 7'd0,   32'd2, 1'b0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd101, 1'b1, 1'b0, 7'd100, 32'd2, 1'b0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd3,   1'b1, 1'b0, 7'd3,   32'd2, 1'b0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd100, 1'b1, 1'b0, 7'd100, 32'd2, 1'b0));
    // fire, pulse, fall
    directed_rows.push_back(mk_row(CmdDuty,    8'd99));
    directed_rows.push_back(mk_row(CmdCross,   8'd0));
    directed_rows.push_back(mk_row(CmdTick,    8'd0));
    directed_rows.push_back(mk_row(CmdTick,    8'd0));
    directed_rows.push_back(mk_row(CmdTick,    8'd0));
    // duty drops to zero while armed: pending expiry still fires
    directed_rows.push_back(mk_row(CmdCross,   8'd0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd1));
    directed_rows.push_back(mk_row(CmdCross,   8'd0));
    directed_rows.push_back(mk_row(CmdTick,    8'd0));
    // thermal warning in the middle of a pulse
    directed_rows.push_back(mk_row(CmdThermal, 8'd0));
    directed_rows.push_back(mk_row(CmdTick,    8'd0));
    directed_rows.push_back(mk_row(CmdTick,    8'd0));
    directed_rows.push_back(mk_row(CmdDuty,    8'd128));
    directed_rows.push_back(mk_row(CmdCross,   8'd0));
    directed_rows.push_back(mk_row(CmdThermal, 8'd255, 1'b1, 1'b0, 7'd0, 32'd6, 1'b1));

    foreach (directed_rows[i]) begin
      offer_item(directed_rows[i].cmd, directed_rows[i].req, directed_rows[i].typed,
                 directed_rows[i].want);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      cmd_ch.valid <= 1'b0;
      do @(negedge clk_i); while (pending_results.size() != 0);
      repeat (4) @(negedge clk_i);
      set_register(RegCpp, cpp_plan[phase]);
      set_register(RegPulse, pulse_plan[phase]);
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 61;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 61;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      // long result-side hold-off while commands keep coming
      if (phase == 4) begin
        hold_off_requests++;
      end
      phase_start = items_sent;
      drained     = 1'b0;
      while (items_sent - phase_start < PhaseItems) begin
        if (!drained && items_sent - phase_start >= PhaseItems / 2) begin
          drained      = 1'b1;
          cmd_ch.valid <= 1'b0;
          do @(negedge clk_i); while (pending_results.size() != 0);
        end
        if ($urandom_range(99) < 20) begin
          offer_item(cmd_e'($urandom_range(3)), 8'($urandom));
        end else begin
          if ($urandom_range(3) == 0) begin
            duty_req = 8'($urandom);
          end else begin
            duty_req = 8'(100 - $urandom_range(25));
          end
          offer_item(CmdDuty, duty_req);
          offer_item(CmdCross, 8'($urandom));
          // enough ticks for delay and pulse, sometimes cut short
          span = int'(ctl_cpp) * (100 - int'(ctl_duty)) + int'(ctl_pulse) +
                 int'($urandom_range(4));
          if (span > 60 || $urandom_range(4) == 0) begin
            span = int'($urandom_range(60, 1));
          end
          repeat (span) offer_item(CmdTick, 8'($urandom));
        end
      end
    end

    cmd_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
